>>> hw/rtl/frame_sequence_timer_defines.svh
// Assertion macros used by the frame sequence timer checker.
`ifndef FRAME_SEQUENCE_TIMER_DEFINES_SVH
`define FRAME_SEQUENCE_TIMER_DEFINES_SVH

// Same-cycle implication, off while reset is low.
`define FST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, off while reset is low.
`define FST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define FST_ASSERT_RESET(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("reset assertion failed");

`endif

>>> hw/rtl/fst_pkg.sv
// Package: constants, codes and types of the frame sequence timer.
package fst_pkg;

    localparam int MAX_FRAMES    = 16;
    localparam int DURATION_BITS = 16;
    localparam int SPRITE_BITS   = 8;
    localparam int POS_BITS      = $clog2(MAX_FRAMES);
    localparam int COUNT_BITS    = $clog2(MAX_FRAMES + 1);
    localparam int OP_BITS       = 2;
    localparam int MODE_BITS     = 2;
    localparam int CFG_BITS      = COUNT_BITS > MODE_BITS ? COUNT_BITS : MODE_BITS;

    localparam logic [OP_BITS-1:0] OP_TICK    = 2'd0;
    localparam logic [OP_BITS-1:0] OP_RESTART = 2'd1;
    localparam logic [OP_BITS-1:0] OP_WRITE   = 2'd2;
    localparam logic [OP_BITS-1:0] OP_NOP     = 2'd3;

    localparam logic [MODE_BITS-1:0] MODE_ONCE   = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_LOOP   = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_BOUNCE = 2'd2;

    localparam logic CFG_PLAY_MODE   = 1'b0;
    localparam logic CFG_FRAME_COUNT = 1'b1;

    typedef logic [MAX_FRAMES-1:0][SPRITE_BITS-1:0]   t_sprite_tab;
    typedef logic [MAX_FRAMES-1:0][DURATION_BITS-1:0] t_duration_tab;

    typedef struct packed {
        logic [DURATION_BITS-1:0] countdown;
        logic [POS_BITS-1:0]      position;
        logic                     backward;
        logic                     ended;
    } t_state;

    typedef struct packed {
        logic [POS_BITS-1:0]    frame_position;
        logic [SPRITE_BITS-1:0] frame_sprite;
        logic                   animation_ended;
        logic                   frame_advanced;
    } t_result;

    typedef struct packed {
        logic                     wr_en;
        logic [POS_BITS-1:0]      wr_index;
        logic [SPRITE_BITS-1:0]   wr_sprite;
        logic [DURATION_BITS-1:0] wr_duration;
    } t_table_wr;

endpackage

>>> hw/rtl/fst_step.sv
// Next-state and result logic for one item of the frame sequence timer.
module fst_step (
    input  fst_pkg::t_state                         i_state,
    input  logic [fst_pkg::MODE_BITS-1:0]           i_play_mode,
    input  logic [fst_pkg::COUNT_BITS-1:0]          i_frame_count,
    input  fst_pkg::t_sprite_tab                    i_sprites,
    input  fst_pkg::t_duration_tab                  i_durations,
    input  logic [fst_pkg::OP_BITS-1:0]             i_op,
    input  logic [fst_pkg::POS_BITS-1:0]            i_entry_index,
    input  logic [fst_pkg::SPRITE_BITS-1:0]         i_entry_sprite,
    input  logic [fst_pkg::DURATION_BITS-1:0]       i_entry_duration,
    output fst_pkg::t_state                         o_state,
    output fst_pkg::t_result                        o_result,
    output fst_pkg::t_table_wr                      o_table_wr
);
    import fst_pkg::*;

    logic [COUNT_BITS-1:0]    n_frames;
    logic [COUNT_BITS-1:0]    pos_inc;
    logic [COUNT_BITS-1:0]    pos_dec;
    logic [COUNT_BITS-1:0]    bounce_back;
    logic                     fwd_past;
    logic                     bwd_past;
    logic [DURATION_BITS-1:0] cd_dec;

    always_comb begin
        if (i_frame_count == '0) begin
            n_frames = COUNT_BITS'(1);
        end else if (i_frame_count > COUNT_BITS'(MAX_FRAMES)) begin
            n_frames = COUNT_BITS'(MAX_FRAMES);
        end else begin
            n_frames = i_frame_count;
        end
    end

    assign pos_inc     = {1'b0, i_state.position} + COUNT_BITS'(1);
    assign pos_dec     = {1'b0, i_state.position} - COUNT_BITS'(1);
    assign bounce_back = n_frames - COUNT_BITS'(2);
    assign fwd_past    = pos_inc >= n_frames;
    assign bwd_past    = (i_state.position == '0) || (pos_dec >= n_frames);
    assign cd_dec      = i_state.countdown - DURATION_BITS'(1);

    always_comb begin
        logic [POS_BITS-1:0] nxt;
        logic                past;
        logic                move;

        o_state    = i_state;
        o_table_wr = '0;
        nxt        = '0;
        past       = 1'b0;
        move       = 1'b0;
        o_result.frame_advanced = 1'b0;

        unique case (i_op)
            OP_TICK: begin
                if (!i_state.ended) begin
                    o_state.countdown = cd_dec;
                    if (cd_dec == '0) begin
                        past = i_state.backward ? bwd_past : fwd_past;
                        if (!past) begin
                            nxt  = i_state.backward ? pos_dec[POS_BITS-1:0]
                                                    : pos_inc[POS_BITS-1:0];
                            move = 1'b1;
                        end else begin
                            priority case (i_play_mode)
                                MODE_LOOP: begin
                                    nxt  = '0;
                                    move = 1'b1;
                                end
                                MODE_BOUNCE: begin
                                    o_state.backward = !i_state.backward;
                                    move = 1'b1;
                                    if (n_frames == COUNT_BITS'(1)) begin
                                        nxt = '0;
                                    end else if (!i_state.backward) begin
                                        nxt = bounce_back[POS_BITS-1:0];
                                    end else begin
                                        nxt = POS_BITS'(1);
                                    end
                                end
                                default: begin
                                    o_state.ended = 1'b1;
                                end
                            endcase
                        end
                        if (move) begin
                            o_state.position  = nxt;
                            o_state.countdown = i_durations[nxt];
                            o_result.frame_advanced = (nxt != i_state.position);
                        end
                    end
                end
            end
            OP_RESTART: begin
                o_state.position  = '0;
                o_state.backward  = 1'b0;
                o_state.ended     = 1'b0;
                o_state.countdown = i_durations[0];
            end
            OP_WRITE: begin
                o_table_wr.wr_en       = 1'b1;
                o_table_wr.wr_index    = i_entry_index;
                o_table_wr.wr_sprite   = i_entry_sprite;
                o_table_wr.wr_duration = i_entry_duration;
                if (i_entry_index == '0) begin
                    o_state.countdown = i_entry_duration;
                end
            end
            OP_NOP: begin
            end
        endcase

        o_result.frame_position  = o_state.position;
        o_result.animation_ended = o_state.ended;
        if (o_table_wr.wr_en && (o_table_wr.wr_index == o_state.position)) begin
            o_result.frame_sprite = i_entry_sprite;
        end else begin
            o_result.frame_sprite = i_sprites[o_state.position];
        end
    end

endmodule

>>> hw/rtl/frame_sequence_timer.sv
// Top level of the frame sequence timer: state, frame table and output skid stage.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one item: a tick (op 0),
//   a restart (op 1), a frame table write (op 2) or a no-op (op 3). Every item
//   gives exactly one result on the output channel (o_out_valid / i_out_stall):
//   the frame position, its sprite id, the ended flag and whether the tick
//   advanced. The result is registered in the output register, or in the skid
//   register while the receiver stalls. Throughput is one item per cycle while
//   o_in_stall is low; countdown, position and table read are combinational.
//   Play mode and frame count are written through i_cfg_we / i_cfg_index /
//   i_cfg_data while no item is in flight.
//   Reset clears countdown, position, direction, ended flag, play mode (once)
//   and frame count (1). Frame table contents are undefined until written.
//   When the receiver stalls, the result holds in the output register and one
//   more item is taken into a skid register; o_in_stall rises only when the
//   skid register is full.
module frame_sequence_timer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [fst_pkg::CFG_BITS-1:0]        i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [fst_pkg::OP_BITS-1:0]         i_op,
    input  logic [fst_pkg::POS_BITS-1:0]        i_entry_index,
    input  logic [fst_pkg::SPRITE_BITS-1:0]     i_entry_sprite,
    input  logic [fst_pkg::DURATION_BITS-1:0]   i_entry_duration,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [fst_pkg::POS_BITS-1:0]        o_frame_position,
    output logic [fst_pkg::SPRITE_BITS-1:0]     o_frame_sprite,
    output logic                                o_animation_ended,
    output logic                                o_frame_advanced
);
    import fst_pkg::*;

    t_state                 r_state;
    t_state                 n_state;
    logic [MODE_BITS-1:0]   r_play_mode;
    logic [COUNT_BITS-1:0]  r_frame_count;
    t_sprite_tab            r_sprites;
    t_duration_tab          r_durations;
    t_result                n_result;
    t_result                r_out;
    t_result                r_skid;
    logic                   r_out_valid;
    logic                   r_skid_valid;
    t_table_wr              tab_wr;
    logic                   accept;
    logic                   out_free;

    assign accept   = i_in_valid && !r_skid_valid;
    assign out_free = !r_out_valid || !i_out_stall;

    fst_step u_step (
        .i_state          (r_state),
        .i_play_mode      (r_play_mode),
        .i_frame_count    (r_frame_count),
        .i_sprites        (r_sprites),
        .i_durations      (r_durations),
        .i_op             (i_op),
        .i_entry_index    (i_entry_index),
        .i_entry_sprite   (i_entry_sprite),
        .i_entry_duration (i_entry_duration),
        .o_state          (n_state),
        .o_result         (n_result),
        .o_table_wr       (tab_wr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= '0;
            r_play_mode   <= MODE_ONCE;
            r_frame_count <= COUNT_BITS'(1);
        end else begin
            if (accept) begin
                r_state <= n_state;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_PLAY_MODE:   r_play_mode   <= i_cfg_data[MODE_BITS-1:0];
                    CFG_FRAME_COUNT: r_frame_count <= i_cfg_data[COUNT_BITS-1:0];
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && tab_wr.wr_en) begin
            r_sprites[tab_wr.wr_index]   <= tab_wr.wr_sprite;
            r_durations[tab_wr.wr_index] <= tab_wr.wr_duration;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept) begin
                r_out <= n_result;
            end
        end else if (accept) begin
            r_skid <= n_result;
        end
    end

    assign o_in_stall        = r_skid_valid;
    assign o_out_valid       = r_out_valid;
    assign o_frame_position  = r_out.frame_position;
    assign o_frame_sprite    = r_out.frame_sprite;
    assign o_animation_ended = r_out.animation_ended;
    assign o_frame_advanced  = r_out.frame_advanced;

endmodule

>>> hw/rtl/fst_checker.sv
// Port-level checker for the frame sequence timer, bound to the top level.
`include "frame_sequence_timer_defines.svh"

module fst_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_in_stall,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  logic [fst_pkg::POS_BITS-1:0]        o_frame_position,
    input  logic [fst_pkg::SPRITE_BITS-1:0]     o_frame_sprite,
    input  logic                                o_animation_ended,
    input  logic                                o_frame_advanced
);

    `FST_ASSERT_RESET(a_reset_clears, i_clk, !i_rst_n, !o_out_valid && !o_in_stall)

    // skid stage only fills behind a held result
    `FST_ASSERT_NOW(a_stall_needs_held, i_clk, i_rst_n, o_in_stall, o_out_valid)

    `FST_ASSERT_NOW(a_skid_after_stall, i_clk, i_rst_n, o_in_stall, $past(i_out_stall))

    // a tick that ends the animation never reports an advance
    `FST_ASSERT_NOW(a_end_no_advance, i_clk, i_rst_n, o_out_valid, !(o_animation_ended && o_frame_advanced))

    `FST_ASSERT_NEXT(a_held_result, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_frame_position) && $stable(o_frame_sprite))

endmodule

bind frame_sequence_timer fst_checker u_fst_checker (.*);
